// ===== hdl/wildcard_date_alarm_table_defines.svh =====
// assertion macros for the wildcard date alarm table
`ifndef WILDCARD_DATE_ALARM_TABLE_DEFINES_SVH
`define WILDCARD_DATE_ALARM_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define WDAT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wdat assertion failed");
`define WDAT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("wdat forbidden condition seen");
`else
`define WDAT_ASSERT(label, clk, rst_n, prop)
`define WDAT_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hdl/wdat_pkg.sv =====
// shared types and constants for the wildcard date alarm table
`timescale 1ns / 1ps
package wdat_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_W       = 5;
    localparam logic [6:0] SEEN_NEVER = 7'd127;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_DEL  = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NONE    = 2'd2,
        STAT_IGNORED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DEL
    } state_t;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } time_t;

    typedef struct packed {
        logic [1:0]  kind;
        time_t       tm;
        logic [4:0]  wild;
        logic [15:0] tag;
        logic [6:0]  seen;
    } entry_t;

    typedef struct packed {
        logic [5:0]  pos;
        logic [1:0]  kind;
        logic [15:0] tag;
    } pend_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hdl/wdat_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module wdat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/wdat_match.sv =====
// compare unit: decides whether one entry is due at the current time
`timescale 1ns / 1ps
module wdat_match
    import wdat_pkg::*;
(
    input  entry_t entry,
    input  time_t  now,
    output logic   due
);

    logic [4:0] differ;
    logic [4:0] earlier;

    always_comb
    begin
        differ[0]  = !entry.wild[0] && (entry.tm.year != now.year);
        differ[1]  = !entry.wild[1] && (entry.tm.month != now.month);
        differ[2]  = !entry.wild[2] && (entry.tm.day != now.day);
        differ[3]  = !entry.wild[3] && (entry.tm.hour != now.hour);
        differ[4]  = !entry.wild[4] && (entry.tm.minute != now.minute);
        earlier[0] = entry.tm.year < now.year;
        earlier[1] = entry.tm.month < now.month;
        earlier[2] = entry.tm.day < now.day;
        earlier[3] = entry.tm.hour < now.hour;
        earlier[4] = entry.tm.minute < now.minute;
    end

    // first differing field decides
    always_comb
    begin
        priority if (differ[0])
        begin
            due = earlier[0];
        end
        else if (differ[1])
        begin
            due = earlier[1];
        end
        else if (differ[2])
        begin
            due = earlier[2];
        end
        else if (differ[3])
        begin
            due = earlier[3];
        end
        else if (differ[4])
        begin
            due = earlier[4];
        end
        else
        begin
            due = 1'b1;
        end
    end

endmodule

// ===== hdl/wildcard_date_alarm_table.sv =====
// top level of the wildcard date alarm table
`timescale 1ns / 1ps
`include "wildcard_date_alarm_table_defines.svh"
// A command is taken when start is high and busy is low. Add, ignored commands
// and rejected deletes finish at once: their single result shows on the cycle
// after the transfer and busy stays low. A delete keeps busy high while the
// entries behind the removed one are copied down one per cycle through the
// entry ram; its result shows in the first cycle that busy is low again.
// A tick keeps busy high while the entries are read from the ram one per cycle
// and each goes through the shared compare unit. Results come out at most one
// per cycle marked by result_valid and cannot be held off, so each must be
// captured when it appears; each firing is held back until the next firing is
// found or the scan ends, and the last result of a tick shows in the first
// cycle that busy is low again. At most sixteen firings are reported per tick,
// although every entry is still tested.
module wildcard_date_alarm_table
    import wdat_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [5:0]  position,
    input  logic [1:0]  task_kind,
    input  logic [13:0] year_value,
    input  logic [3:0]  month_value,
    input  logic [4:0]  day_value,
    input  logic [4:0]  hour_value,
    input  logic [5:0]  minute_value,
    input  logic [4:0]  wildcard_mask,
    input  logic [15:0] action_tag,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [5:0]  entry_position,
    output logic [1:0]  fired_kind,
    output logic [15:0] fired_tag,
    output logic        last_of_run
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             rvalid_reg, rvalid_next;
    logic [AW-1:0]    pidx_reg, pidx_next;
    time_t            now_reg, now_next;
    logic [5:0]       dpos_reg, dpos_next;
    logic [RES_W-1:0] nres_reg, nres_next;
    pend_t            pend_reg, pend_next;
    logic             have_pend_reg, have_pend_next;

    logic             res_valid_reg, res_valid_next;
    status_t          res_status_reg, res_status_next;
    logic [5:0]       res_pos_reg, res_pos_next;
    logic [1:0]       res_kind_reg, res_kind_next;
    logic [15:0]      res_tag_reg, res_tag_next;
    logic             res_last_reg, res_last_next;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    entry_t           ram_wdata;
    logic [AW-1:0]    ram_raddr;
    entry_t           ram_rdata;
    entry_t           new_entry;
    entry_t           wb_entry;
    logic             issue;
    logic             due;
    logic [5:0]       del_pos;

    wdat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wdat_match u_match (
        .entry (ram_rdata),
        .now   (now_reg),
        .due   (due)
    );

    assign issue   = idx_reg < count_reg;
    assign del_pos = (position > 6'(count_reg)) ? 6'(count_reg) : position;

    always_comb
    begin
        new_entry.kind      = task_kind;
        new_entry.tm.year   = year_value;
        new_entry.tm.month  = month_value;
        new_entry.tm.day    = day_value;
        new_entry.tm.hour   = hour_value;
        new_entry.tm.minute = minute_value;
        new_entry.wild      = wildcard_mask;
        new_entry.tag       = action_tag;
        new_entry.seen      = SEEN_NEVER;
        wb_entry            = ram_rdata;
        wb_entry.seen       = {1'b0, now_reg.minute};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (command == CMD_TICK))
                begin
                    state_next = ST_SCAN;
                end
                else if (start && (command == CMD_DEL) && (position != 6'd0)
                         && (count_reg != '0))
                begin
                    state_next = ST_DEL;
                end
            end
            ST_SCAN, ST_DEL:
            begin
                if (!issue && !rvalid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and results
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        rvalid_next     = 1'b0;
        pidx_next       = idx_reg[AW-1:0];
        now_next        = now_reg;
        dpos_next       = dpos_reg;
        nres_next       = nres_reg;
        pend_next       = pend_reg;
        have_pend_next  = have_pend_reg;
        res_valid_next  = 1'b0;
        res_status_next = STAT_DONE;
        res_pos_next    = 6'd0;
        res_kind_next   = 2'd0;
        res_tag_next    = 16'd0;
        res_last_next   = 1'b1;
        ram_we          = 1'b0;
        ram_waddr       = pidx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_e_t'(command))
                        CMD_ADD:
                        begin
                            res_valid_next = 1'b1;
                            if (task_kind == 2'd0)
                            begin
                                res_status_next = STAT_IGNORED;
                            end
                            else if (count_reg >= CW'(MAX_ENTRIES))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = count_reg[AW-1:0];
                                ram_wdata    = new_entry;
                                count_next   = count_reg + CW'(1);
                                res_pos_next = 6'(count_reg) + 6'd1;
                            end
                        end
                        CMD_DEL:
                        begin
                            if (position == 6'd0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_IGNORED;
                            end
                            else if (count_reg == '0)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = STAT_NONE;
                            end
                            else
                            begin
                                dpos_next = del_pos;
                                idx_next  = CW'(del_pos);
                            end
                        end
                        CMD_TICK:
                        begin
                            now_next.year   = year_value;
                            now_next.month  = month_value;
                            now_next.day    = day_value;
                            now_next.hour   = hour_value;
                            now_next.minute = minute_value;
                            idx_next        = '0;
                            nres_next       = '0;
                            have_pend_next  = 1'b0;
                        end
                        CMD_NONE:
                        begin
                            res_valid_next  = 1'b1;
                            res_status_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rvalid_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    if (ram_rdata.seen != {1'b0, now_reg.minute})
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = wb_entry;
                        if (due && (nres_reg < RES_W'(MAX_RESULTS)))
                        begin
                            // earlier firing goes out now, newest waits
                            if (have_pend_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_pos_next   = pend_reg.pos;
                                res_kind_next  = pend_reg.kind;
                                res_tag_next   = pend_reg.tag;
                                res_last_next  = 1'b0;
                            end
                            pend_next.pos  = 6'(pidx_reg) + 6'd1;
                            pend_next.kind = ram_rdata.kind;
                            pend_next.tag  = ram_rdata.tag;
                            have_pend_next = 1'b1;
                            nres_next      = nres_reg + RES_W'(1);
                        end
                    end
                end
                else if (!issue)
                begin
                    res_valid_next = 1'b1;
                    if (have_pend_reg)
                    begin
                        res_pos_next  = pend_reg.pos;
                        res_kind_next = pend_reg.kind;
                        res_tag_next  = pend_reg.tag;
                    end
                    else
                    begin
                        res_status_next = STAT_NONE;
                    end
                end
            end
            ST_DEL:
            begin
                rvalid_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rvalid_reg)
                begin
                    // copy entry one place down
                    ram_we    = 1'b1;
                    ram_waddr = pidx_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                else if (!issue)
                begin
                    count_next     = count_reg - CW'(1);
                    res_valid_next = 1'b1;
                    res_pos_next   = dpos_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            rvalid_reg    <= 1'b0;
            nres_reg      <= '0;
            have_pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rvalid_reg    <= rvalid_next;
            nres_reg      <= nres_next;
            have_pend_reg <= have_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg       <= pidx_next;
        now_reg        <= now_next;
        dpos_reg       <= dpos_next;
        pend_reg       <= pend_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_kind_reg   <= res_kind_next;
        res_tag_reg    <= res_tag_next;
        res_last_reg   <= res_last_next;
    end

    assign busy           = state_reg != ST_IDLE;
    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign entry_position = res_pos_reg;
    assign fired_kind     = res_kind_reg;
    assign fired_tag      = res_tag_reg;
    assign last_of_run    = res_last_reg;

    `WDAT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(MAX_ENTRIES))
    `WDAT_ASSERT(a_nres_bound, clk, rst_n, nres_reg <= RES_W'(MAX_RESULTS))
    `WDAT_ASSERT(a_scan_write, clk, rst_n, ram_we && (state_reg == ST_SCAN) |-> rvalid_reg)
    `WDAT_ASSERT(a_tick_quiet, clk, rst_n, start && !busy && (command == CMD_TICK) |=> !result_valid)
    `WDAT_ASSERT_NEVER(a_del_empty, clk, rst_n, (state_reg == ST_DEL) && (count_reg == '0))

endmodule
